/* rtl/core/short_filename_normalizer_top_assert.svh */
// Assertion macros for the short file name normalizer.
// Used by short_filename_normalizer_top; depends on nothing else.
`ifndef SHORT_FILENAME_NORMALIZER_TOP_ASSERT_SVH
`define SHORT_FILENAME_NORMALIZER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SNFN_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SNFN_ASSERT(lbl, prop, msg) \
    `SNFN_ASSERT_IMPL(lbl, i_clk, i_rst_n, prop, msg)
`else
`define SNFN_ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define SNFN_ASSERT(lbl, prop, msg)
`endif
`endif

/* rtl/core/snfn_pkg.sv */
// Shared types, constants and helper functions of the short file name normalizer.
// Used by snfn_ctrl, snfn_dp and short_filename_normalizer_top.
package snfn_pkg;

    localparam int BYTE_W     = 8;
    localparam int BASE_CNT_W = 4;

    localparam logic [BASE_CNT_W-1:0] BASE_CNT_MAX = 4'd15;
    localparam logic [BYTE_W-1:0]     CASE_GAP     = 8'h20;
    localparam logic [BYTE_W-1:0]     PAD_CHAR     = 8'h20;
    localparam logic [BYTE_W-1:0]     DOT_CHAR     = 8'h2E;
    localparam logic [BYTE_W-1:0]     END_CHAR     = 8'h00;
    localparam logic [BYTE_W-1:0]     LOWER_A      = 8'h61;
    localparam logic [BYTE_W-1:0]     LOWER_Z      = 8'h7A;
    localparam logic [BYTE_W-1:0]     CHAR_B       = 8'h42;
    localparam logic [BYTE_W-1:0]     CHAR_I       = 8'h49;
    localparam logic [BYTE_W-1:0]     CHAR_N       = 8'h4E;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic pad_emit;
        logic ext_emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;
        logic is_end;
        logic pad_need;
        logic pad_last;
        logic ext_last;
    } t_status;

    function automatic logic [BYTE_W-1:0] to_upper(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] res;
        res = c;
        if (c >= LOWER_A && c <= LOWER_Z) begin
            res = c - CASE_GAP;
        end
        return res;
    endfunction

    // Extension given to a name that has no dot.
    function automatic logic [BYTE_W-1:0] default_ext(input logic [1:0] idx);
        logic [BYTE_W-1:0] res;
        case (idx)
            2'd0:    res = CHAR_B;
            2'd1:    res = CHAR_I;
            2'd2:    res = CHAR_N;
            default: res = END_CHAR;
        endcase
        return res;
    endfunction

endpackage

/* rtl/core/short_filename_normalizer_top.sv */
// Short file name normalizer: folds a byte stream into an 8.3 style name.
// Top level; depends on snfn_pkg, snfn_ctrl, snfn_dp and the assertion header.
//
// Usage: file name bytes enter on the input channel (i_in_valid, o_in_ready,
// i_name_char), one byte per beat, and a zero byte ends the name. Result beats
// leave on the output channel (o_out_valid, i_out_ready, o_out_char,
// o_last_of_name). A base name byte gives one registered result beat in the cycle
// after it is accepted; a dot or an extension byte gives none. Ordinary bytes are
// taken one per cycle while the receiver keeps up.
// The ending byte starts a drain of max(0, BASE_LEN - base length) space beats
// and then EXT_LEN extension beats, the last one flagged by o_last_of_name.
// The drain issues one beat per cycle through the single output register while
// the output channel is not stalled, and no input byte is taken during it.
// A stall on the output channel holds the output register and, with it, the
// input channel and the drain. Reset empties the output register and returns
// the block to base name mode with an empty extension.
`include "short_filename_normalizer_top_assert.svh"

module short_filename_normalizer_top #(
    parameter int BASE_LEN = 8,
    parameter int EXT_LEN  = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [snfn_pkg::BYTE_W-1:0] i_name_char,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [snfn_pkg::BYTE_W-1:0] o_out_char,
    output logic                        o_last_of_name
);

    snfn_pkg::t_cmd    cmd;
    snfn_pkg::t_status status;

    snfn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    snfn_dp #(
        .BASE_LEN (BASE_LEN),
        .EXT_LEN  (EXT_LEN)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_name_char    (i_name_char),
        .i_out_ready    (i_out_ready),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_out_char     (o_out_char),
        .o_last_of_name (o_last_of_name)
    );

    // The ending byte always opens a drain, so the next cycle takes no byte.
    `SNFN_ASSERT(a_end_starts_drain, cmd.accept && status.is_end |=> !o_in_ready, "input taken right after the ending byte")

    // The final extension beat must show up flagged in the output register.
    `SNFN_ASSERT(a_last_flagged, cmd.ext_emit && status.ext_last |=> o_out_valid && o_last_of_name, "final extension beat not flagged")

    // A drain step only issues while the output register can take it.
    `SNFN_ASSERT(a_drain_has_room, cmd.pad_emit || cmd.ext_emit |-> status.slot_free && !o_in_ready, "drain step without output room")

endmodule

/* rtl/core/snfn_ctrl.sv */
// Controller of the short file name normalizer: gates the input channel and
// sequences the padding and extension drain that follows the ending byte. Depends on snfn_pkg.
module snfn_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  snfn_pkg::t_status i_status,
    output snfn_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PAD  = 2'd1;
    localparam logic [1:0] S_EXT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.pad_emit = 1'b0;
        o_cmd.ext_emit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = i_status.slot_free;
                o_cmd.accept = i_in_valid && i_status.slot_free;
                if (o_cmd.accept && i_status.is_end) begin
                    n_state = i_status.pad_need ? S_PAD : S_EXT;
                end
            end
            S_PAD: begin
                if (i_status.slot_free) begin
                    o_cmd.pad_emit = 1'b1;
                    if (i_status.pad_last) begin
                        n_state = S_EXT;
                    end
                end
            end
            S_EXT: begin
                if (i_status.slot_free) begin
                    o_cmd.ext_emit = 1'b1;
                    if (i_status.ext_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/core/snfn_dp.sv */
// Datapath of the short file name normalizer: name state, extension store
// and the output register. Depends on snfn_pkg.
module snfn_dp #(
    parameter int BASE_LEN = 8,
    parameter int EXT_LEN  = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [snfn_pkg::BYTE_W-1:0]   i_name_char,
    input  logic                          i_out_ready,
    input  snfn_pkg::t_cmd                i_cmd,
    output snfn_pkg::t_status             o_status,
    output logic                          o_out_valid,
    output logic [snfn_pkg::BYTE_W-1:0]   o_out_char,
    output logic                          o_last_of_name
);

    localparam int EXT_IW = (EXT_LEN > 1) ? $clog2(EXT_LEN) : 1;
    localparam int EXT_CW = $clog2(EXT_LEN + 1);

    logic                               r_in_ext,   n_in_ext;
    logic [snfn_pkg::BASE_CNT_W-1:0]    r_base_len, n_base_len;
    logic [snfn_pkg::BYTE_W-1:0]        r_ext_bytes [EXT_LEN];
    logic [snfn_pkg::BYTE_W-1:0]        n_ext_bytes [EXT_LEN];
    logic [EXT_CW-1:0]                  r_ext_cnt,  n_ext_cnt;
    logic [EXT_IW-1:0]                  r_ext_idx,  n_ext_idx;
    logic                               r_out_valid, n_out_valid;
    logic [snfn_pkg::BYTE_W-1:0]        r_out_char;
    logic                               r_out_last;

    logic                               load;
    logic [snfn_pkg::BYTE_W-1:0]        ld_char;
    logic                               ld_last;
    logic                               ext_last;
    logic [snfn_pkg::BYTE_W-1:0]        upper_char;

    assign ext_last   = (r_ext_idx == EXT_IW'(EXT_LEN - 1));
    assign upper_char = snfn_pkg::to_upper(i_name_char);

    assign o_status.slot_free = !r_out_valid || i_out_ready;
    assign o_status.is_end    = (i_name_char == snfn_pkg::END_CHAR);
    assign o_status.pad_need  = (r_base_len < snfn_pkg::BASE_CNT_W'(BASE_LEN));
    assign o_status.pad_last  = (r_base_len == snfn_pkg::BASE_CNT_W'(BASE_LEN - 1));
    assign o_status.ext_last  = ext_last;

    always_comb begin
        n_in_ext    = r_in_ext;
        n_base_len  = r_base_len;
        n_ext_bytes = r_ext_bytes;
        n_ext_cnt   = r_ext_cnt;
        n_ext_idx   = r_ext_idx;
        load        = 1'b0;
        ld_char     = snfn_pkg::PAD_CHAR;
        ld_last     = 1'b0;

        if (i_cmd.accept) begin
            if (i_name_char == snfn_pkg::END_CHAR) begin
                n_ext_idx = '0;
            end else if (!r_in_ext) begin
                if (i_name_char == snfn_pkg::DOT_CHAR) begin
                    n_in_ext = 1'b1;
                end else begin
                    load    = 1'b1;
                    ld_char = upper_char;
                    if (r_base_len != snfn_pkg::BASE_CNT_MAX) begin
                        n_base_len = r_base_len + 1'b1;
                    end
                end
            end else if (r_ext_cnt < EXT_CW'(EXT_LEN)) begin
                // Bytes past the extension length are dropped silently.
                n_ext_bytes[r_ext_cnt[EXT_IW-1:0]] = upper_char;
                n_ext_cnt = r_ext_cnt + 1'b1;
            end
        end

        if (i_cmd.pad_emit) begin
            load       = 1'b1;
            ld_char    = snfn_pkg::PAD_CHAR;
            n_base_len = r_base_len + 1'b1;
        end

        if (i_cmd.ext_emit) begin
            load    = 1'b1;
            ld_char = r_in_ext ? r_ext_bytes[r_ext_idx] : snfn_pkg::default_ext(2'(r_ext_idx));
            ld_last = ext_last;
            if (ext_last) begin
                // The name is complete, so the state goes back to its reset value.
                n_in_ext   = 1'b0;
                n_base_len = '0;
                n_ext_cnt  = '0;
                n_ext_idx  = '0;
                for (int k = 0; k < EXT_LEN; k++) begin
                    n_ext_bytes[k] = snfn_pkg::END_CHAR;
                end
            end else begin
                n_ext_idx = r_ext_idx + 1'b1;
            end
        end

        if (load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ext    <= 1'b0;
            r_base_len  <= '0;
            r_ext_cnt   <= '0;
            r_ext_idx   <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < EXT_LEN; k++) begin
                r_ext_bytes[k] <= snfn_pkg::END_CHAR;
            end
        end else begin
            r_in_ext    <= n_in_ext;
            r_base_len  <= n_base_len;
            r_ext_cnt   <= n_ext_cnt;
            r_ext_idx   <= n_ext_idx;
            r_out_valid <= n_out_valid;
            r_ext_bytes <= n_ext_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_char <= ld_char;
            r_out_last <= ld_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_char     = r_out_char;
    assign o_last_of_name = r_out_last;

endmodule
